FILE: rtl/bcds_pkg.sv
// bcds_pkg: types, constants and small digit helpers for the button counter
// and digit scanner; no dependencies, used by every other rtl file
`timescale 1ns / 1ps

package bcds_pkg;

   localparam int unsigned CountWidth = 7;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CsrWidth   = 16;

   localparam logic [CountWidth-1:0] CountMax       = 7'd99;
   localparam logic [CsrWidth-1:0]   LongPressReset = 16'd500;
   localparam logic [TimeWidth-1:0]  PressTimeReset = 32'd1;
   localparam logic [3:0]            Radix          = 4'd10;

   // active-low digit enables for each scan phase
   localparam logic [3:0] SelSumOnes   = 4'h7;
   localparam logic [3:0] SelSumTens   = 4'hB;
   localparam logic [3:0] SelCountOnes = 4'hD;
   localparam logic [3:0] SelCountTens = 4'hE;

   typedef enum logic {
      OP_BUTTON = 1'b0,
      OP_SCAN   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PHASE_SUM_ONES   = 2'd0,
      PHASE_SUM_TENS   = 2'd1,
      PHASE_COUNT_ONES = 2'd2,
      PHASE_COUNT_TENS = 2'd3
   } scan_phase_type;

   typedef struct packed {
      op_type                 operation;
      logic                   button_level;
      logic [TimeWidth-1:0]   time_ms;
   } req_item_type;

   typedef struct packed {
      logic [3:0]             digit_select;
      logic [3:0]             bcd_pins;
      logic                   point;
      logic [CountWidth-1:0]  count_value;
   } rsp_item_type;

   // tens digit of a value 0..99, by reciprocal multiply (205 / 2048)
   function automatic logic [3:0] tens_of(input logic [CountWidth-1:0] value);
      logic [14:0] prod;
      prod = 15'(value) * 15'd205;
      return prod[14:11];
   endfunction

   // bcd pins carry the digit msb on bit 0
   function automatic logic [3:0] reverse_nibble(input logic [3:0] digit);
      return {digit[0], digit[1], digit[2], digit[3]};
   endfunction

endpackage

FILE: rtl/bcds_channels.sv
// bcds channel interfaces: valid/ready request and response channels
// depends on bcds_pkg for field widths
`timescale 1ns / 1ps

interface bcds_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic                          button_level;
   logic [bcds_pkg::TimeWidth-1:0] time_ms;

   modport source (output valid, output operation, output button_level,
                   output time_ms, input ready);
   modport sink   (input valid, input operation, input button_level,
                   input time_ms, output ready);
endinterface

interface bcds_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [3:0]                     digit_select;
   logic [3:0]                     bcd_pins;
   logic                           point;
   logic [bcds_pkg::CountWidth-1:0] count_value;

   modport source (output valid, output digit_select, output bcd_pins,
                   output point, output count_value, input ready);
   modport sink   (input valid, input digit_select, input bcd_pins,
                   input point, input count_value, output ready);
endinterface

FILE: rtl/bcds_in_stage.sv
// bcds_in_stage: input register holding one request item for the core
// depends on bcds_pkg
`timescale 1ns / 1ps

module bcds_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bcds_pkg::req_item_type req_item,
   output logic                   item_valid,
   output bcds_pkg::req_item_type item,
   input  logic                   item_take
);

   logic                   vld_ff;
   logic                   vld_in;
   bcds_pkg::req_item_type item_ff;
   logic                   load;

   assign req_ready = !vld_ff || item_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (item_take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/bcds_core.sv
// bcds_core: count and scan state, digit logic and the result register
// depends on bcds_pkg
`timescale 1ns / 1ps

module bcds_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bcds_pkg::CsrWidth-1:0]  long_press_ms,
   input  logic                           item_valid,
   input  bcds_pkg::req_item_type         item,
   output logic                           item_take,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bcds_pkg::rsp_item_type         rsp_item
);

   logic [bcds_pkg::CountWidth-1:0] count_ff, count_in;
   logic [bcds_pkg::TimeWidth-1:0]  press_time_ff, press_time_in;
   bcds_pkg::scan_phase_type        phase_ff, phase_in;
   logic [3:0]                      select_ff, select_in;
   logic [3:0]                      bcd_ff, bcd_in;
   logic                            point_ff, point_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   bcds_pkg::rsp_item_type          rsp_ff, rsp_in;

   logic [3:0]                      tens;
   logic [3:0]                      ones;
   logic [4:0]                      sum;
   logic [3:0]                      sum_tens;
   logic [3:0]                      sum_ones;
   logic [3:0]                      digit;
   logic [bcds_pkg::TimeWidth-1:0]  delta;
   logic                            long_release;

   assign item_take = item_valid && (!rsp_vld_ff || rsp_ready);

   always_comb begin
      tens     = bcds_pkg::tens_of(count_ff);
      ones     = 4'(count_ff - 7'(tens) * 7'(bcds_pkg::Radix));
      sum      = 5'(tens) + 5'(ones);
      sum_tens = (sum >= 5'(bcds_pkg::Radix)) ? 4'd1 : 4'd0;
      sum_ones = (sum >= 5'(bcds_pkg::Radix)) ? 4'(sum - 5'(bcds_pkg::Radix))
                                              : sum[3:0];
      // release delay wraps modulo 2^32
      delta        = item.time_ms - press_time_ff;
      long_release = delta > bcds_pkg::TimeWidth'(long_press_ms);
   end

   always_comb begin
      count_in      = count_ff;
      press_time_in = press_time_ff;
      phase_in      = phase_ff;
      select_in     = select_ff;
      bcd_in        = bcd_ff;
      point_in      = point_ff;
      digit         = tens;
      if (item_take) begin
         unique case (item.operation)
            bcds_pkg::OP_BUTTON: begin
               if (item.button_level) begin
                  count_in      = (count_ff >= bcds_pkg::CountMax) ? '0 : count_ff + 7'd1;
                  press_time_in = item.time_ms;
               end else if (long_release) begin
                  count_in = '0;
               end
            end
            bcds_pkg::OP_SCAN: begin
               unique case (phase_ff)
                  bcds_pkg::PHASE_SUM_ONES: begin
                     select_in = bcds_pkg::SelSumOnes;
                     digit     = sum_ones;
                  end
                  bcds_pkg::PHASE_SUM_TENS: begin
                     select_in = bcds_pkg::SelSumTens;
                     digit     = sum_tens;
                  end
                  bcds_pkg::PHASE_COUNT_ONES: begin
                     select_in = bcds_pkg::SelCountOnes;
                     digit     = ones;
                     point_in  = 1'b1;
                  end
                  bcds_pkg::PHASE_COUNT_TENS: begin
                     select_in = bcds_pkg::SelCountTens;
                     digit     = tens;
                     point_in  = 1'b0;
                  end
                  default: begin
                     select_in = select_ff;
                  end
               endcase
               bcd_in   = bcds_pkg::reverse_nibble(digit);
               phase_in = bcds_pkg::scan_phase_type'(2'(phase_ff + 2'd1));
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (item_take) begin
         rsp_vld_in          = 1'b1;
         rsp_in.digit_select = select_in;
         rsp_in.bcd_pins     = bcd_in;
         rsp_in.point        = point_in;
         rsp_in.count_value  = count_in;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         press_time_ff <= bcds_pkg::PressTimeReset;
         phase_ff      <= bcds_pkg::PHASE_SUM_ONES;
         select_ff     <= '0;
         bcd_ff        <= '0;
         point_ff      <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         count_ff      <= count_in;
         press_time_ff <= press_time_in;
         phase_ff      <= phase_in;
         select_ff     <= select_in;
         bcd_ff        <= bcd_in;
         point_ff      <= point_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bcds_pkg::CountMax)
      else $error("count out of range");

   a_count_wrap: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.operation == bcds_pkg::OP_BUTTON && item.button_level
       && count_ff == bcds_pkg::CountMax) |=> (count_ff == '0))
      else $error("count did not wrap to zero");

   a_scan_one_digit: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.operation == bcds_pkg::OP_SCAN)
      |=> (rsp_vld_ff && $countones(~rsp_ff.digit_select) == 1))
      else $error("scan item did not enable exactly one digit");

   a_phase_steps: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.operation == bcds_pkg::OP_SCAN)
      |=> (phase_ff == 2'($past(phase_ff) + 2'd1)))
      else $error("scan phase did not advance");

endmodule

FILE: rtl/button_counter_digit_scan.sv
// button_counter_digit_scan: items pass the input register, then the result register
// throughput one item per cycle while the result is taken; each register holds one item
// ready falls only when both registers are full and the result is not taken
// reset is synchronous, active high: count 0, press time 1, scan phase 0,
// display pins 0, long_press_ms 500, both registers empty
`timescale 1ns / 1ps

module button_counter_digit_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bcds_pkg::CsrWidth-1:0] csr_wr_data,
   bcds_req_if.sink                      req_chan,
   bcds_rsp_if.source                    rsp_chan
);

   logic [bcds_pkg::CsrWidth-1:0] long_press_ff;
   bcds_pkg::req_item_type        req_item;
   bcds_pkg::req_item_type        item;
   logic                          item_valid;
   logic                          item_take;
   bcds_pkg::rsp_item_type        rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= bcds_pkg::LongPressReset;
      end else if (csr_wr_en) begin
         long_press_ff <= csr_wr_data;
      end
   end

   always_comb begin
      req_item.operation    = bcds_pkg::op_type'(req_chan.operation);
      req_item.button_level = req_chan.button_level;
      req_item.time_ms      = req_chan.time_ms;
   end

   bcds_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   bcds_core u_core (
      .clock         (clock),
      .reset         (reset),
      .long_press_ms (long_press_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_item      (rsp_item)
   );

   assign rsp_chan.digit_select = rsp_item.digit_select;
   assign rsp_chan.bcd_pins     = rsp_item.bcd_pins;
   assign rsp_chan.point        = rsp_item.point;
   assign rsp_chan.count_value  = rsp_item.count_value;

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for button_counter_digit_scan, with a queue-fed driver,
// a clocked monitor and an item-level predictor of the count and the scan pins
// depends on bcds_pkg, the bcds channel interfaces and the rtl top level
`timescale 1ns / 1ps

module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [bcds_pkg::CsrWidth-1:0] csr_wr_data = '0;

   bcds_req_if req_bus ();
   bcds_rsp_if rsp_bus ();

   button_counter_digit_scan dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source)
   );

   // predicted block state
   logic [bcds_pkg::CountWidth-1:0] m_count = '0;
   logic [bcds_pkg::TimeWidth-1:0]  m_press = bcds_pkg::PressTimeReset;
   bcds_pkg::scan_phase_type        m_phase = bcds_pkg::PHASE_SUM_ONES;
   logic [3:0]                      m_sel = '0;
   logic [3:0]                      m_bcd = '0;
   logic                            m_point = 1'b0;
   logic [bcds_pkg::CsrWidth-1:0]   m_long_press = bcds_pkg::LongPressReset;

   bcds_pkg::req_item_type pending_items[$];
   bcds_pkg::rsp_item_type expected_pins[$];
   bcds_pkg::req_item_type drv_item;

   int unsigned send_idle = 16;
   int unsigned recv_idle = 85;
   int unsigned mismatches = 0;
   int unsigned queued = 0;
   int unsigned hold_left = 0;
   logic hold_arm = 1'b0;
   logic [bcds_pkg::TimeWidth-1:0] now_ms = '0;

   initial forever #4 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = bcds_pkg::OP_BUTTON;
      req_bus.button_level = 1'b0;
      req_bus.time_ms = '0;
      rsp_bus.ready = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic bcds_pkg::rsp_item_type step_display(input bcds_pkg::req_item_type it);
      bcds_pkg::rsp_item_type r;
      logic [bcds_pkg::TimeWidth-1:0] held;
      int unsigned tens, ones, sum, digit;
      logic [3:0] d;
      if (it.operation == bcds_pkg::OP_BUTTON) begin
         if (it.button_level) begin
            m_count = (m_count >= bcds_pkg::CountMax) ? '0 : m_count + 7'd1;
            m_press = it.time_ms;
         end else begin
            held = it.time_ms - m_press;
            if (held > {16'd0, m_long_press}) m_count = '0;
         end
      end else begin
         tens = 32'(m_count) / 32'(bcds_pkg::Radix);
         ones = 32'(m_count) % 32'(bcds_pkg::Radix);
         sum = tens + ones;
         case (m_phase)
            bcds_pkg::PHASE_SUM_ONES: begin
               m_sel = bcds_pkg::SelSumOnes;
               digit = sum % 32'(bcds_pkg::Radix);
            end
            bcds_pkg::PHASE_SUM_TENS: begin
               m_sel = bcds_pkg::SelSumTens;
               digit = sum / 32'(bcds_pkg::Radix);
            end
            bcds_pkg::PHASE_COUNT_ONES: begin
               m_sel = bcds_pkg::SelCountOnes;
               digit = ones;
               m_point = 1'b1;
            end
            default: begin
               m_sel = bcds_pkg::SelCountTens;
               digit = tens;
               m_point = 1'b0;
            end
         endcase
         d = digit[3:0];
         // pins carry the digit msb first
         for (int i = 0; i < 4; i++) m_bcd[i] = d[3-i];
         m_phase = bcds_pkg::scan_phase_type'(m_phase + 2'd1);
      end
      r.digit_select = m_sel;
      r.bcd_pins = m_bcd;
      r.point = m_point;
      r.count_value = m_count;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned seen,
                                input int unsigned wanted);
      if (mismatches < 40)
         $display("mismatch %s: got %0h want %0h at %0t", what, seen, wanted, $realtime);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) expected_pins.push_back(step_display(drv_item));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
               drv_item = pending_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.operation <= drv_item.operation;
               req_bus.button_level <= drv_item.button_level;
               req_bus.time_ms <= drv_item.time_ms;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm) begin
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      bcds_pkg::rsp_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pins.size() == 0) begin
               flag_mismatch("unexpected item", 32'(rsp_bus.count_value), 0);
            end else begin
               want = expected_pins.pop_front();
               if (rsp_bus.digit_select !== want.digit_select)
                  flag_mismatch("digit_select", 32'(rsp_bus.digit_select),
                                32'(want.digit_select));
               if (rsp_bus.bcd_pins !== want.bcd_pins)
                  flag_mismatch("bcd_pins", 32'(rsp_bus.bcd_pins), 32'(want.bcd_pins));
               if (rsp_bus.point !== want.point)
                  flag_mismatch("point", 32'(rsp_bus.point), 32'(want.point));
               if (rsp_bus.count_value !== want.count_value)
                  flag_mismatch("count_value", 32'(rsp_bus.count_value),
                                32'(want.count_value));
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic queue_item(input bcds_pkg::op_type op, input logic lvl,
                             input logic [bcds_pkg::TimeWidth-1:0] t);
      bcds_pkg::req_item_type it;
      it.operation = op;
      it.button_level = lvl;
      it.time_ms = t;
      pending_items.push_back(it);
      queued++;
   endtask

   task automatic queue_scan();
      queue_item(bcds_pkg::OP_SCAN, 1'($urandom_range(1)), $urandom());
   endtask

   // checked between edges so the driver and monitor have settled
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_bus.valid || expected_pins.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_long_press(input logic [bcds_pkg::CsrWidth-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m_long_press = value;
   endtask

   task automatic build_random(input int unsigned quota);
      int unsigned start, pick, n;
      logic [bcds_pkg::TimeWidth-1:0] delay;
      start = queued;
      while (queued - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 3) now_ms = $urandom();
         else if (pick < 5) now_ms = 32'hFFFF_FFFF - $urandom_range(300);
         else now_ms = now_ms + $urandom_range(1, 50);
         pick = $urandom_range(99);
         if (pick < 60) begin
            // press then release: short, near the threshold, or long
            n = $urandom_range(99);
            if (n < 70) delay = $urandom_range(m_long_press);
            else if (n < 88) delay = {16'd0, m_long_press} + $urandom_range(2) - 1;
            else delay = {16'd0, m_long_press} + 1 + $urandom_range(100000);
            queue_item(bcds_pkg::OP_BUTTON, 1'b1, now_ms);
            now_ms = now_ms + delay;
            queue_item(bcds_pkg::OP_BUTTON, 1'b0, now_ms);
            repeat ($urandom_range(4)) queue_scan();
         end else if (pick < 82) begin
            repeat ($urandom_range(4, 8)) queue_scan();
         end else if (pick < 87) begin
            // long run of presses to walk the count through its wrap
            repeat ($urandom_range(40, 105)) begin
               now_ms = now_ms + $urandom_range(20);
               queue_item(bcds_pkg::OP_BUTTON, 1'b1, now_ms);
               if ($urandom_range(9) < 3) queue_scan();
            end
         end else if (pick < 93) begin
            queue_item(bcds_pkg::OP_BUTTON, 1'b1, now_ms);
            queue_scan();
         end else begin
            queue_item(bcds_pkg::op_type'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom());
         end
      end
   endtask

   initial begin
      logic [bcds_pkg::CsrWidth-1:0] settings[6];
      settings[0] = 16'd0;
      settings[1] = 16'hFFFF;
      settings[2] = 16'($urandom());
      settings[3] = 16'd1;
      settings[4] = bcds_pkg::LongPressReset;
      settings[5] = 16'($urandom());

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all scan phases, threshold edge across the timestamp wrap
      queue_scan();
      queue_item(bcds_pkg::OP_SCAN, 1'b1, 32'hFFFF_FFFF);
      queue_scan();
      queue_item(bcds_pkg::OP_SCAN, 1'b0, 32'h0);
      queue_item(bcds_pkg::OP_BUTTON, 1'b1, 32'hFFFF_FF00);
      queue_item(bcds_pkg::OP_BUTTON, 1'b1, 32'hFFFF_FFF0);
      queue_item(bcds_pkg::OP_BUTTON, 1'b0, 32'h0000_01E4);
      queue_item(bcds_pkg::OP_BUTTON, 1'b1, 32'hFFFF_FFFF);
      repeat (4) queue_scan();
      queue_item(bcds_pkg::OP_BUTTON, 1'b0, 32'h0000_01F4);
      queue_item(bcds_pkg::OP_BUTTON, 1'b1, 32'h0);
      queue_item(bcds_pkg::OP_BUTTON, 1'b0, 32'h0);
      repeat (4) queue_scan();
      queue_item(bcds_pkg::OP_BUTTON, 1'b0, 32'hFFFF_FFFF);
      queue_item(bcds_pkg::OP_BUTTON, 1'b0, 32'h1234_5678);
      repeat (2) queue_scan();
      wait_idle();

      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 2) begin
            send_idle <= 16;
            recv_idle <= 85;
         end else if (seg < 4) begin
            send_idle <= 85;
            recv_idle <= 16;
         end else begin
            send_idle <= 0;
            recv_idle <= 0;
         end
         write_long_press(settings[seg]);
         build_random(305);
         if (seg == 4) begin
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_pins.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
